FILE: design/prf_pkg.sv
// Package for the prime range filter: controller state encoding and the
// command/status bundles between controller and datapath. No dependencies.
package prf_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_BOUND = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_BOUND = 2'd1;

  localparam longint RST_LOWER_BOUND = 100;
  localparam longint RST_UPPER_BOUND = 300;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RANGE = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_STEP  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_div;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic sq_gt_n;
    logic div_last;
    logic rem_zero;
    logic out_free;
  } status_t;

endpackage

FILE: design/prf_if.sv
// Valid/ready stream interfaces for the prime range filter channels.
// No dependencies.
interface prf_cand_if #(parameter int VALUE_WIDTH = 16) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface prf_prime_if #(parameter int VALUE_WIDTH = 16) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] prime_value;
  modport source (output valid, output prime_value, input ready);
  modport sink   (input valid, input prime_value, output ready);
endinterface

FILE: design/prf_ctrl.sv
// Controller state machine for the prime range filter.
// Uses prf_pkg for state, command and status types.
module prf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  prf_pkg::status_t status,
  output prf_pkg::cmd_t    cmd
);

  prf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == prf_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      prf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = prf_pkg::ST_RANGE;
        end
      end
      prf_pkg::ST_RANGE: begin
        state_next = status.in_range ? prf_pkg::ST_CHECK : prf_pkg::ST_IDLE;
      end
      prf_pkg::ST_CHECK: begin
        if (status.sq_gt_n) begin
          state_next = prf_pkg::ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next = prf_pkg::ST_DIV;
        end
      end
      prf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = prf_pkg::ST_STEP;
        end
      end
      prf_pkg::ST_STEP: begin
        if (status.rem_zero) begin
          state_next = prf_pkg::ST_IDLE;
        end else begin
          cmd.next_div = 1'b1;
          state_next = prf_pkg::ST_CHECK;
        end
      end
      prf_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = prf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = prf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/prf_datapath.sv
// Datapath for the prime range filter: candidate, trial divisor with running
// square, bit-serial remainder unit and output register. Uses prf_pkg.
module prf_datapath #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] lower_bound,
  input  logic [VALUE_WIDTH-1:0] upper_bound,
  input  logic [VALUE_WIDTH-1:0] in_data,
  input  prf_pkg::cmd_t          cmd,
  output prf_pkg::status_t       status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_data
);

  localparam int D_W   = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int SQ_W  = VALUE_WIDTH + 2;
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] n;
  logic [D_W-1:0]         div;
  logic [SQ_W-1:0]        sq;
  logic [D_W-1:0]         rem;
  logic [CNT_W-1:0]       cnt;

  logic [D_W:0] shifted;
  logic [D_W:0] diff;

  assign shifted = {rem, n[cnt]};
  assign diff    = shifted - {1'b0, div};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n   <= in_data;
      div <= D_W'(2);
      sq  <= SQ_W'(4);
    end
    if (cmd.next_div) begin
      div <= div + D_W'(1);
      sq  <= sq + SQ_W'({div, 1'b1});
    end
    if (cmd.div_start) begin
      rem <= '0;
      cnt <= CNT_W'(VALUE_WIDTH - 1);
    end
    if (cmd.div_step) begin
      rem <= (shifted >= {1'b0, div}) ? diff[D_W-1:0] : shifted[D_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= n;
    end
  end

  assign status.in_range = (n >= lower_bound) && (n <= upper_bound)
                           && (n >= VALUE_WIDTH'(2));
  assign status.sq_gt_n  = sq > SQ_W'(n);
  assign status.div_last = (cnt == '0);
  assign status.rem_zero = (rem == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

FILE: design/prime_range_filter_top.sv
// Top level of the prime range filter: configuration registers, controller
// and datapath. Depends on prf_pkg, prf_if, prf_ctrl and prf_datapath.
//
//  port     | dir | beat content
//  ---------+-----+--------------------------------------------
//  cand     | in  | candidate, number to test
//  result   | out | prime_value, candidate that is prime and in range
//  cfg_*    | in  | write enable, register index, write data
//
// One candidate at a time. Each accepted candidate is range-checked, then
// divided in turn by each trial divisor d with d*d <= n until one divides
// it; a prime in range is then emitted. The bit-serial remainder unit takes
// one dividend bit per cycle.
// Reset (rst, synchronous) loads bounds 100 and 300 and empties the output.
// The output register holds a result while the next candidate is accepted;
// a new result waits in the controller until the register is free.
module prime_range_filter_top #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  prf_cand_if.sink                         cand,
  prf_prime_if.source                      result,
  input  logic                             cfg_wr_en,
  input  logic [prf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [VALUE_WIDTH-1:0]           cfg_data
);

  localparam longint VAL_MAX = (longint'(1) << VALUE_WIDTH) - 1;
  localparam logic [VALUE_WIDTH-1:0] LOWER_RST =
    (prf_pkg::RST_LOWER_BOUND > VAL_MAX) ? '1 : VALUE_WIDTH'(prf_pkg::RST_LOWER_BOUND);
  localparam logic [VALUE_WIDTH-1:0] UPPER_RST =
    (prf_pkg::RST_UPPER_BOUND > VAL_MAX) ? '1 : VALUE_WIDTH'(prf_pkg::RST_UPPER_BOUND);

  logic [VALUE_WIDTH-1:0] lower_bound;
  logic [VALUE_WIDTH-1:0] upper_bound;

  prf_pkg::cmd_t    cmd;
  prf_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= LOWER_RST;
      upper_bound <= UPPER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        prf_pkg::REG_LOWER_BOUND: lower_bound <= cfg_data;
        prf_pkg::REG_UPPER_BOUND: upper_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  prf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cand.valid),
    .in_ready (cand.ready),
    .status   (status),
    .cmd      (cmd)
  );

  prf_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .in_data     (cand.candidate),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_data    (result.prime_value)
  );

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.next_div, cmd.emit}))
    else $error("controller issued overlapping commands");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result.valid || result.ready))
    else $error("result register overwritten while a beat is pending");

  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.prime_value >= lower_bound)
                     && (result.prime_value <= upper_bound)
                     && (result.prime_value >= VALUE_WIDTH'(2)))
    else $error("emitted value outside configured range");

  a_load_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !cand.ready)
    else $error("controller took a beat while busy");

endmodule
